### rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and codes for the point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Configuration register index width and codes
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUERY_X = 2'd0,
    CFG_QUERY_Y = 2'd1
  } pip_cfg_idx_e;

  // Per-edge control flags, produced with the products
  typedef struct packed {
    logic straddle;  // edge crosses the horizontal line through the query
    logic den_pos;   // sign of yb - ya when straddling
  } pip_edge_flags_t;

endpackage

### rtl/core/pip_rel_stage.sv
// ----------------------------------------------------------------------------
// pip_rel_stage
// Makes each vertex relative to the query point, keeps the first and
// previous vertex of the polygon and loads the first pipeline register.
// ----------------------------------------------------------------------------
module pip_rel_stage #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic signed [CoordBits-1:0] vertex_x_i,
  input  logic signed [CoordBits-1:0] vertex_y_i,
  input  logic                        last_vertex_i,
  input  logic signed [CoordBits-1:0] query_x_i,
  input  logic signed [CoordBits-1:0] query_y_i,
  output logic signed [CoordBits:0]   cur_x_o,
  output logic signed [CoordBits:0]   cur_y_o,
  output logic signed [CoordBits:0]   prev_x_o,
  output logic signed [CoordBits:0]   prev_y_o,
  output logic signed [CoordBits:0]   first_x_o,
  output logic signed [CoordBits:0]   first_y_o,
  output logic                        has_prev_o,
  output logic                        last_o
);
  localparam int unsigned RelBits = CoordBits + 1;

  logic signed [RelBits-1:0] rel_x, rel_y;
  logic signed [RelBits-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic                      have_first_q;

  // exact difference, one extra bit
  assign rel_x = {vertex_x_i[CoordBits-1], vertex_x_i} - {query_x_i[CoordBits-1], query_x_i};
  assign rel_y = {vertex_y_i[CoordBits-1], vertex_y_i} - {query_y_i[CoordBits-1], query_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
    end else if (load_i) begin
      have_first_q <= ~last_vertex_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prev_x_q <= rel_x;
      prev_y_q <= rel_y;
      if (!have_first_q) begin
        first_x_q <= rel_x;
        first_y_q <= rel_y;
      end
      // stage-1 payload
      cur_x_o    <= rel_x;
      cur_y_o    <= rel_y;
      prev_x_o   <= prev_x_q;
      prev_y_o   <= prev_y_q;
      first_x_o  <= have_first_q ? first_x_q : rel_x;
      first_y_o  <= have_first_q ? first_y_q : rel_y;
      has_prev_o <= have_first_q;
      last_o     <= last_vertex_i;
    end
  end

endmodule

### rtl/core/pip_edge_mul.sv
// ----------------------------------------------------------------------------
// pip_edge_mul
// Cross products and straddle flags of one edge a->b.
// ----------------------------------------------------------------------------
module pip_edge_mul #(
  parameter int unsigned RelBits = 17
) (
  input  logic signed [RelBits-1:0]   xa_i,
  input  logic signed [RelBits-1:0]   ya_i,
  input  logic signed [RelBits-1:0]   xb_i,
  input  logic signed [RelBits-1:0]   yb_i,
  output logic signed [2*RelBits-1:0] xb_ya_o,
  output logic signed [2*RelBits-1:0] xa_yb_o,
  output pip_pkg::pip_edge_flags_t    flags_o
);
  import pip_pkg::*;

  logic ya_pos, yb_pos;

  assign ya_pos = ~ya_i[RelBits-1] & (|ya_i);
  assign yb_pos = ~yb_i[RelBits-1] & (|yb_i);

  assign xb_ya_o = xb_i * ya_i;
  assign xa_yb_o = xa_i * yb_i;

  assign flags_o.straddle = yb_pos ^ ya_pos;
  // when straddling, yb - ya > 0 exactly when yb > 0
  assign flags_o.den_pos  = yb_pos;

endmodule

### rtl/core/pip_cross_eval.sv
// ----------------------------------------------------------------------------
// pip_cross_eval
// Sign test on registered products: does the edge cross left of the query.
// ----------------------------------------------------------------------------
module pip_cross_eval #(
  parameter int unsigned RelBits = 17
) (
  input  logic signed [2*RelBits-1:0] xb_ya_i,
  input  logic signed [2*RelBits-1:0] xa_yb_i,
  input  pip_pkg::pip_edge_flags_t    flags_i,
  output logic                        cross_o
);
  import pip_pkg::*;

  localparam int unsigned ProdBits = 2 * RelBits;

  logic signed [ProdBits:0] num;
  logic                     num_nz, num_pos;

  assign num     = {xb_ya_i[ProdBits-1], xb_ya_i} - {xa_yb_i[ProdBits-1], xa_yb_i};
  assign num_nz  = |num;
  assign num_pos = ~num[ProdBits] & num_nz;
  assign cross_o = flags_i.straddle & num_nz & (num_pos == flags_i.den_pos);

endmodule

### rtl/core/point_in_polygon_ray_crossing.sv
// ----------------------------------------------------------------------------
// point_in_polygon_ray_crossing
// The accepted last vertex passes the stage-1 and stage-2 registers into the result register behind inside_res_o.
// Throughput: one vertex per cycle; stages hold only while a result waits.
// Relative coordinates feed the stage-1 register; products are registered in
// stage 2, and the sign tests feed the result register.
// Reset: query registers, valids, parity and first-vertex flag clear at once.
// ----------------------------------------------------------------------------
// Streams polygon vertices and classifies the configured query point with
// the even-odd crossing rule. Per vertex, the edge from the previous vertex
// is tested; on the last vertex the closing edge to the first is tested too.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_crossing #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // vertex request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        vertex_x_i,
  input  logic signed [COORD_BITS-1:0]        vertex_y_i,
  input  logic                                last_vertex_i,
  // result request channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                inside_res_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pip_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i
);
  import pip_pkg::*;

  localparam int unsigned RelBits  = COORD_BITS + 1;
  localparam int unsigned ProdBits = 2 * RelBits;

  // --------------------------------------------------------------------------
  // Configuration: query point. Writes are always taken; unknown indexes
  // are dropped.
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] query_x_q, query_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
    end else if (cfg_valid_i) begin
      case (pip_cfg_idx_e'(cfg_index_i))
        CFG_QUERY_X: query_x_q <= cfg_data_i;
        CFG_QUERY_Y: query_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. A stage moves on when the next one is free. A non-last
  // vertex leaves the sign-test stage without a result, so only last
  // vertices wait for the output register.
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic s2_last_q, s2_has_prev_q;
  logic out_free, s2_retire, s2_free, s1_free, in_acc;

  assign out_free   = ~out_v_q | out_ready_i;
  assign s2_retire  = s2_v_q & (~s2_last_q | out_free);
  assign s2_free    = ~s2_v_q | s2_retire;
  assign s1_free    = ~s1_v_q | s2_free;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i & s1_free;

  // --------------------------------------------------------------------------
  // Stage 1: relative coordinates and polygon bookkeeping
  // --------------------------------------------------------------------------
  logic signed [RelBits-1:0] s1_cur_x, s1_cur_y, s1_prev_x, s1_prev_y;
  logic signed [RelBits-1:0] s1_first_x, s1_first_y;
  logic                      s1_has_prev, s1_last;

  pip_rel_stage #(
    .CoordBits (COORD_BITS)
  ) u_rel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_acc),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .query_x_i     (query_x_q),
    .query_y_i     (query_y_q),
    .cur_x_o       (s1_cur_x),
    .cur_y_o       (s1_cur_y),
    .prev_x_o      (s1_prev_x),
    .prev_y_o      (s1_prev_y),
    .first_x_o     (s1_first_x),
    .first_y_o     (s1_first_y),
    .has_prev_o    (s1_has_prev),
    .last_o        (s1_last)
  );

  // --------------------------------------------------------------------------
  // Stage 2: products for the incoming edge (prev->cur) and the closing
  // edge (cur->first); two multipliers per edge.
  // --------------------------------------------------------------------------
  logic signed [ProdBits-1:0] in_p0, in_p1, cl_p0, cl_p1;
  pip_edge_flags_t            in_flags, cl_flags;

  pip_edge_mul #(
    .RelBits (RelBits)
  ) u_mul_in (
    .xa_i    (s1_prev_x),
    .ya_i    (s1_prev_y),
    .xb_i    (s1_cur_x),
    .yb_i    (s1_cur_y),
    .xb_ya_o (in_p0),
    .xa_yb_o (in_p1),
    .flags_o (in_flags)
  );

  pip_edge_mul #(
    .RelBits (RelBits)
  ) u_mul_close (
    .xa_i    (s1_cur_x),
    .ya_i    (s1_cur_y),
    .xb_i    (s1_first_x),
    .yb_i    (s1_first_y),
    .xb_ya_o (cl_p0),
    .xa_yb_o (cl_p1),
    .flags_o (cl_flags)
  );

  logic signed [ProdBits-1:0] s2_in_p0_q, s2_in_p1_q, s2_cl_p0_q, s2_cl_p1_q;
  pip_edge_flags_t            s2_in_flags_q, s2_cl_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= in_valid_i;
      if (s2_free) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_in_p0_q    <= in_p0;
      s2_in_p1_q    <= in_p1;
      s2_cl_p0_q    <= cl_p0;
      s2_cl_p1_q    <= cl_p1;
      s2_in_flags_q <= in_flags;
      s2_cl_flags_q <= cl_flags;
      s2_has_prev_q <= s1_has_prev;
      s2_last_q     <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sign tests, parity and result register
  // --------------------------------------------------------------------------
  logic in_cross, cl_cross;
  logic parity_q, parity_new;
  logic inside_q;

  pip_cross_eval #(
    .RelBits (RelBits)
  ) u_eval_in (
    .xb_ya_i (s2_in_p0_q),
    .xa_yb_i (s2_in_p1_q),
    .flags_i (s2_in_flags_q),
    .cross_o (in_cross)
  );

  pip_cross_eval #(
    .RelBits (RelBits)
  ) u_eval_close (
    .xb_ya_i (s2_cl_p0_q),
    .xa_yb_i (s2_cl_p1_q),
    .flags_i (s2_cl_flags_q),
    .cross_o (cl_cross)
  );

  // first vertex has no incoming edge; closing edge only on the last vertex
  assign parity_new = parity_q ^ (s2_has_prev_q & in_cross) ^ (s2_last_q & cl_cross);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (s2_retire) begin
        parity_q <= s2_last_q ? 1'b0 : parity_new;
      end
      if (s2_retire && s2_last_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_retire && s2_last_q) begin
      inside_q <= parity_new;
    end
  end

  assign out_valid_o  = out_v_q;
  assign inside_res_o = inside_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_in_lands_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_v_q)
    else $error("accepted vertex did not reach stage 1");

  a_parity_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_retire && s2_last_q) |=> !parity_q)
    else $error("parity not cleared after polygon end");

  a_out_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s2_v_q && s2_last_q))
    else $error("result raised without a last vertex");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |-> !(s2_retire && s2_last_q))
    else $error("pending result overwritten");

endmodule
